@@ hw/rtl/bse_pkg.sv @@
// shared types, operation codes and sizes for the bit store enumerator
package bse_pkg;

	localparam int TOTAL_BITS_DEFAULT = 65536;
	localparam int WORD_BITS = 64;
	localparam int SEL_W = 6;
	localparam int LIM_W = 7;
	localparam int WN_W = 10;
	localparam int MAX_WORDS = 1024;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	localparam logic [1:0] OP_SET = 2'd0;
	localparam logic [1:0] OP_TEST = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_COLLECT = 2'd3;

	// classified request as it waits in the queue
	typedef struct packed {
		logic [1:0] op;
		logic [WN_W-1:0] addr;
		logic [SEL_W-1:0] bit_sel;
		logic in_range;
		logic [LIM_W-1:0] lim;
		logic word_zero;
	} bse_entry_t;

	typedef struct packed {
		logic valid;
		bse_entry_t entry;
	} bse_head_t;

	typedef struct packed {
		logic pop;
		logic init;
	} bse_back_ctl_t;

endpackage

@@ hw/rtl/bitmap_set_bit_enumerator.sv @@
// top level of the bit store with set bit enumeration
//
// Requests enter on start while busy is low and carry operation, bit_index,
// word_idx and bound. A front stage classifies each request into a
// two-entry queue; the back side runs them in order against a store of
// TOTAL_BITS/64 words held in one memory with a registered read port.
// Each result appears for one cycle with strobe high; the receiver cannot
// stall, so results are never held. last marks the final result of a request.
// Steps per request on the back side, set by the single memory port:
//   set and test: read, then write back or answer
//   collect: read, then one index per cycle for the found bits, or one empty result
//   clear all: a sweep that clears every word of the store, then the answer
// After the back side takes a request, a set or test passes the execute state
// and then the registered strobe, a collect the execute and the emit state; a
// clear all answers in the cycle after its last word is cleared. busy is high
// while the queue is full. After reset the store is zeroed by a sweep of one
// word per cycle with busy held high.
module bitmap_set_bit_enumerator #(
	parameter int TOTAL_BITS = bse_pkg::TOTAL_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] operation,
	input logic [15:0] bit_index,
	input logic [bse_pkg::WN_W-1:0] word_idx,
	input logic [16:0] bound,
	output logic strobe,
	output logic test_result,
	output logic [15:0] found_index,
	output logic found_valid,
	output logic [15:0] slot,
	output logic last
);
	import bse_pkg::*;

	bse_head_t head;
	bse_back_ctl_t ctl;

	bse_front #(
		.TOTAL_BITS(TOTAL_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.bit_index(bit_index),
		.word_idx(word_idx),
		.bound(bound),
		.ctl(ctl),
		.head(head)
	);

	bse_back #(
		.TOTAL_BITS(TOTAL_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.ctl(ctl),
		.strobe(strobe),
		.test_result(test_result),
		.found_index(found_index),
		.found_valid(found_valid),
		.slot(slot),
		.last(last)
	);

endmodule

@@ hw/rtl/bse_front.sv @@
// request classification and the short queue ahead of the execution side
module bse_front #(
	parameter int TOTAL_BITS = bse_pkg::TOTAL_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] operation,
	input logic [15:0] bit_index,
	input logic [bse_pkg::WN_W-1:0] word_idx,
	input logic [16:0] bound,
	input bse_pkg::bse_back_ctl_t ctl,
	output bse_pkg::bse_head_t head
);
	import bse_pkg::*;

	localparam int STORE_WORDS = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WORDS = (STORE_WORDS > MAX_WORDS) ? MAX_WORDS : STORE_WORDS;
	localparam logic [20:0] TOTAL_LIM = 21'(TOTAL_BITS);
	localparam logic [WN_W:0] WORDS_LIM = (WN_W + 1)'(WORDS);

	bse_entry_t entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic push;
	bse_entry_t cls;
	logic [15:0] base;
	logic [17:0] diff;

	assign busy = (cnt_q == QCNT_W'(QDEPTH)) || ctl.init;
	assign push = start && !busy;

	// collect window: number of bits of the word that lie below the bound
	assign base = {word_idx, 6'b0};
	assign diff = {1'b0, bound} - {2'b0, base};

	always_comb begin
		cls.op = operation;
		cls.bit_sel = bit_index[SEL_W-1:0];
		cls.word_zero = (word_idx == '0);
		if (operation == OP_COLLECT) begin
			cls.addr = word_idx;
			cls.in_range = ({1'b0, word_idx} < WORDS_LIM);
		end else begin
			cls.addr = bit_index[15:SEL_W];
			cls.in_range = ({5'b0, bit_index} < TOTAL_LIM);
		end
		if ({1'b0, bound} <= {2'b0, base}) begin
			cls.lim = '0;
		end else if (diff >= 18'(WORD_BITS)) begin
			cls.lim = LIM_W'(WORD_BITS);
		end else begin
			cls.lim = diff[LIM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (ctl.pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, ctl.pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	assign head.valid = (cnt_q != '0);
	assign head.entry = entry_q[rd_ptr_q];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> cnt_q != '0)
		else $error("pop from empty queue");

endmodule

@@ hw/rtl/bse_back.sv @@
// bit store memory, clearing sweep and set bit enumeration
module bse_back #(
	parameter int TOTAL_BITS = bse_pkg::TOTAL_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input bse_pkg::bse_head_t head,
	output bse_pkg::bse_back_ctl_t ctl,
	output logic strobe,
	output logic test_result,
	output logic [15:0] found_index,
	output logic found_valid,
	output logic [15:0] slot,
	output logic last
);
	import bse_pkg::*;

	localparam int STORE_WORDS = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WORDS = (STORE_WORDS > MAX_WORDS) ? MAX_WORDS : STORE_WORDS;
	localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORDS - 1);

	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_EXEC = 3'd2;
	localparam logic [2:0] ST_EMIT = 3'd3;
	localparam logic [2:0] ST_CLR = 3'd4;

	logic [WORD_BITS-1:0] mem [WORDS];
	logic [WORD_BITS-1:0] rdata_q;
	logic [2:0] state_q;
	bse_entry_t cur_q;
	logic [ADDR_W-1:0] sweep_q;
	logic [WORD_BITS-1:0] scan_q;
	logic [16:0] count_q;

	logic we;
	logic [ADDR_W-1:0] waddr;
	logic [WORD_BITS-1:0] wdata;
	logic [WORD_BITS-1:0] word;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] lowest;
	logic [WORD_BITS-1:0] rest;
	logic [SEL_W-1:0] pos;

	logic res_en;
	logic res_test;
	logic [15:0] res_index;
	logic res_valid;
	logic [15:0] res_slot;
	logic res_last;

	assign ctl.init = (state_q == ST_INIT);
	assign ctl.pop = (state_q == ST_IDLE) && head.valid;

	// out of range words read as zero
	assign word = cur_q.in_range ? rdata_q : '0;
	assign mask = (cur_q.lim >= LIM_W'(WORD_BITS)) ? '1 :
		((WORD_BITS'(1) << cur_q.lim) - WORD_BITS'(1));

	// lowest set bit of the remaining scan word and its position
	assign lowest = scan_q & (~scan_q + WORD_BITS'(1));
	assign rest = scan_q & ~lowest;
	always_comb begin
		pos = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			if (lowest[j]) begin
				pos = pos | SEL_W'(j);
			end
		end
	end

	always_comb begin
		we = 1'b0;
		waddr = sweep_q;
		wdata = '0;
		case (state_q)
			ST_INIT, ST_CLR: we = 1'b1;
			ST_EXEC: begin
				waddr = cur_q.addr[ADDR_W-1:0];
				wdata = rdata_q | (WORD_BITS'(1) << cur_q.bit_sel);
				we = (cur_q.op == OP_SET) && cur_q.in_range;
			end
			default: we = 1'b0;
		endcase
	end

	always_comb begin
		res_en = 1'b0;
		res_test = 1'b0;
		res_index = '0;
		res_valid = 1'b0;
		res_slot = '0;
		res_last = 1'b1;
		case (state_q)
			ST_EXEC: begin
				res_en = (cur_q.op == OP_SET) || (cur_q.op == OP_TEST);
				res_test = (cur_q.op == OP_TEST) && word[cur_q.bit_sel];
			end
			ST_EMIT: begin
				res_en = 1'b1;
				if (scan_q != '0) begin
					res_index = {cur_q.addr, pos};
					res_valid = 1'b1;
					res_slot = count_q[15:0];
					res_last = (rest == '0);
				end
			end
			ST_CLR: res_en = (sweep_q == LAST_ADDR);
			default: res_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[head.entry.addr[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			sweep_q <= '0;
			count_q <= '0;
			strobe <= 1'b0;
		end else begin
			strobe <= res_en;
			case (state_q)
				ST_INIT, ST_CLR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == LAST_ADDR) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (head.valid) begin
						state_q <= (head.entry.op == OP_CLEAR) ? ST_CLR : ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cur_q.op == OP_COLLECT) begin
						state_q <= ST_EMIT;
						if (cur_q.word_zero) begin
							count_q <= '0;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (scan_q != '0) begin
						count_q <= count_q + 17'd1;
					end
					if (res_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			cur_q <= head.entry;
		end
		if (state_q == ST_EXEC) begin
			scan_q <= word & mask;
		end else if (state_q == ST_EMIT) begin
			scan_q <= rest;
		end
		test_result <= res_test;
		found_index <= res_index;
		found_valid <= res_valid;
		slot <= res_slot;
		last <= res_last;
	end

	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INIT |=> !strobe)
		else $error("result during reset sweep");

	a_found_no_test: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && found_valid |-> !test_result)
		else $error("test bit set on a collect result");

	a_slot_step: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && found_valid && !last |=>
			strobe && found_valid && slot == $past(slot) + 16'd1)
		else $error("collect results not back to back with rising slot");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !we)
		else $error("store written while idle");

endmodule

@@ dv/tb.sv @@
// self-checking testbench for the bit store set-bit enumerator
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bse_pkg::*;

	localparam int STORE_BITS = TOTAL_BITS_DEFAULT;
	localparam int STORE_WORDS = STORE_BITS / WORD_BITS;
	localparam int STALL_LIMIT = 6000;
	localparam int RUN_ITEMS = 120;
	localparam int TAIL_ITEMS = 20;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic test_result;
		logic [15:0] found_index;
		logic found_valid;
		logic [15:0] slot;
		logic last;
	} scan_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] operation;
	logic [15:0] bit_index;
	logic [WN_W-1:0] word_idx;
	logic [16:0] bound;
	logic strobe;
	logic test_result;
	logic [15:0] found_index;
	logic found_valid;
	logic [15:0] slot;
	logic last;

	// shadow copy of the store and the running found count
	logic [WORD_BITS-1:0] shadow_words [STORE_WORDS];
	logic [16:0] found_total;
	scan_result_t pending_results [$];

	int requests_sent;
	int op_count [4];
	int results_checked;
	int indices_found;
	int mismatch_count;
	int stall_cycles;
	bit gaps_on;

	bitmap_set_bit_enumerator dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.bit_index(bit_index),
		.word_idx(word_idx),
		.bound(bound),
		.strobe(strobe),
		.test_result(test_result),
		.found_index(found_index),
		.found_valid(found_valid),
		.slot(slot),
		.last(last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic shadow_bit(input int unsigned b);
		if (b >= STORE_BITS)
			return 1'b0;
		return shadow_words[b / WORD_BITS][b % WORD_BITS];
	endfunction

	// work out the results that one accepted request must produce
	task automatic predict_scan(input logic [1:0] op, input logic [15:0] idx,
			input logic [WN_W-1:0] wn, input logic [16:0] bnd);
		int unsigned hits [$];
		int unsigned b;
		scan_result_t r;
		r = '0;
		r.last = 1'b1;
		case (op)
			OP_SET: begin
				if (idx < STORE_BITS)
					shadow_words[idx[15:6]][idx[5:0]] = 1'b1;
				pending_results.push_back(r);
			end
			OP_TEST: begin
				r.test_result = shadow_bit(32'(idx));
				pending_results.push_back(r);
			end
			OP_CLEAR: begin
				foreach (shadow_words[w])
					shadow_words[w] = '0;
				pending_results.push_back(r);
			end
			default: begin
				if (wn == '0)
					found_total = '0;
				for (int j = 0; j < WORD_BITS; j++) begin
					b = int'(wn) * WORD_BITS + j;
					if (b < 32'(bnd) && shadow_bit(b))
						hits.push_back(b);
				end
				if (hits.size() == 0)
					pending_results.push_back(r);
				foreach (hits[k]) begin
					b = hits[k];
					r.found_index = b[15:0];
					r.found_valid = 1'b1;
					r.slot = found_total[15:0];
					r.last = (k == hits.size() - 1);
					found_total = found_total + 17'd1;
					pending_results.push_back(r);
				end
			end
		endcase
	endtask

	// drive start low and the fields random at each falling edge
	task automatic hold_off(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start = 1'b0;
			operation = 2'($urandom);
			bit_index = 16'($urandom);
			word_idx = WN_W'($urandom);
			bound = 17'($urandom);
		end
	endtask

	task automatic send_request(input logic [1:0] op, input logic [15:0] idx,
			input logic [WN_W-1:0] wn, input logic [16:0] bnd);
		@(negedge clk);
		start = 1'b1;
		operation = op;
		bit_index = idx;
		word_idx = wn;
		bound = bnd;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_scan(op, idx, wn, bnd);
		requests_sent++;
		op_count[op]++;
		if (gaps_on && $urandom_range(0, 2) == 0)
			hold_off($urandom_range(1, 14));
	endtask

	task automatic wait_drained();
		hold_off(1);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic void note_mismatch(input string what, input scan_result_t want,
			input scan_result_t seen);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$display("%t %s: expected test=%0b idx=%0d valid=%0b slot=%0d last=%0b",
				$realtime, what, want.test_result, want.found_index, want.found_valid,
				want.slot, want.last);
			$display("    got test=%0b idx=%0d valid=%0b slot=%0d last=%0b",
				seen.test_result, seen.found_index, seen.found_valid, seen.slot,
				seen.last);
		end
	endfunction

	always @(posedge clk) begin : check_results
		scan_result_t seen;
		scan_result_t want;
		if (arst_n && strobe) begin
			seen = '{test_result, found_index, found_valid, slot, last};
			results_checked++;
			if (pending_results.size() == 0) begin
				note_mismatch("result with nothing pending", '0, seen);
			end else begin
				want = pending_results.pop_front();
				if (want.found_valid)
					indices_found++;
				if (seen.test_result !== want.test_result ||
						seen.found_index !== want.found_index ||
						seen.found_valid !== want.found_valid ||
						seen.slot !== want.slot || seen.last !== want.last)
					note_mismatch("result mismatch", want, seen);
			end
		end
	end

	// a clear-all or the reset sweep runs with no traffic while it clears the store
	always @(posedge clk) begin
		if ((start && !busy) || strobe)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("no progress for %0d cycles, %0d results pending", stall_cycles,
				pending_results.size());
			$display("** bitmap_set_bit_enumerator: FAILED **");
			$finish;
		end
	end

	task automatic test_after_reset();
		send_request(OP_TEST, 16'd0, '0, 17'd0);
		send_request(OP_TEST, 16'hFFFF, '1, 17'h1FFFF);
		send_request(OP_COLLECT, 16'd0, '0, 17'd65536);
	endtask

	task automatic test_set_and_test();
		send_request(OP_SET, 16'd0, '0, 17'd0);
		send_request(OP_SET, 16'd63, '0, 17'd0);
		send_request(OP_SET, 16'd64, '0, 17'd0);
		send_request(OP_SET, 16'hFFFF, '1, 17'h1FFFF);
		send_request(OP_SET, 16'h5555, '0, 17'd0);
		send_request(OP_SET, 16'hAAAA, '0, 17'd0);
		send_request(OP_TEST, 16'd63, '0, 17'd0);
		send_request(OP_TEST, 16'd62, '0, 17'd0);
		send_request(OP_TEST, 16'hFFFF, '0, 17'd0);
		send_request(OP_TEST, 16'hAAAA, '0, 17'd0);
	endtask

	task automatic test_collect_bounds();
		send_request(OP_COLLECT, 16'd0, 10'd0, 17'd0);
		send_request(OP_COLLECT, 16'd0, 10'd0, 17'd1);
		send_request(OP_COLLECT, 16'd0, 10'd0, 17'd65536);
		// slots carry on from word 0
		send_request(OP_COLLECT, 16'd0, 10'd1, 17'd65536);
		send_request(OP_COLLECT, 16'd0, 10'd1023, 17'd65535);
		// bound past the end of the store
		send_request(OP_COLLECT, 16'd0, 10'd1023, 17'h1FFFF);
		send_request(OP_COLLECT, 16'd0, 10'd0, 17'd64);
	endtask

	task automatic test_clear_all();
		wait_drained();
		send_request(OP_CLEAR, 16'hFFFF, '1, 17'h1FFFF);
		send_request(OP_TEST, 16'd0, '0, 17'd0);
		send_request(OP_SET, 16'd320, '0, 17'd0);
		// clear leaves the found count alone
		send_request(OP_COLLECT, 16'd0, 10'd5, 17'd65536);
		send_request(OP_COLLECT, 16'd0, 10'd0, 17'd65536);
	endtask

	// mostly set/test/walk sequences from word 0 upward, the rest random requests
	task automatic test_random_walks();
		int top;
		logic [1:0] op;
		logic [16:0] lim;
		while (requests_sent < RUN_ITEMS - TAIL_ITEMS) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 3) != 0) begin
				top = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 12) : $urandom_range(0, 2);
				repeat ($urandom_range(1, 8))
					send_request(OP_SET,
						16'($urandom_range(0, (top + 1) * WORD_BITS - 1)),
						WN_W'($urandom), 17'($urandom));
				repeat ($urandom_range(0, 2))
					send_request(OP_TEST,
						16'($urandom_range(0, (top + 1) * WORD_BITS - 1)),
						WN_W'($urandom), 17'($urandom));
				lim = ($urandom_range(0, 3) != 0) ? 17'd65536 :
					17'($urandom_range(0, (top + 1) * WORD_BITS));
				for (int w = 0; w <= top; w++)
					send_request(OP_COLLECT, 16'($urandom), WN_W'(w), lim);
				if ($urandom_range(0, 3) == 0)
					wait_drained();
			end else begin
				op = 2'($urandom_range(0, 3));
				if (op == OP_CLEAR && $urandom_range(0, 7) != 0)
					op = OP_TEST;
				lim = $urandom_range(0, 1) ? 17'($urandom) : 17'($urandom_range(0, 65536));
				send_request(op, 16'($urandom),
					$urandom_range(0, 1) ? WN_W'($urandom_range(0, 15)) : WN_W'($urandom),
					lim);
			end
		end
	endtask

	task automatic test_back_to_back();
		gaps_on = 1'b0;
		repeat (TAIL_ITEMS - 6)
			send_request(OP_SET, 16'($urandom_range(0, 2 * WORD_BITS - 1)),
				WN_W'($urandom), 17'($urandom));
		send_request(OP_COLLECT, 16'($urandom), 10'd0, 17'd65536);
		send_request(OP_COLLECT, 16'($urandom), 10'd1, 17'd65536);
		repeat (4)
			send_request(OP_TEST, 16'($urandom_range(0, 2 * WORD_BITS - 1)),
				WN_W'($urandom), 17'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_SET;
		bit_index = '0;
		word_idx = '0;
		bound = '0;
		found_total = '0;
		foreach (shadow_words[w])
			shadow_words[w] = '0;
		gaps_on = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_after_reset();
		test_set_and_test();
		test_collect_bounds();
		test_clear_all();
		test_random_walks();
		test_back_to_back();

		hold_off(1);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("ran %0d requests: %0d set, %0d test, %0d clear, %0d collect",
			requests_sent, op_count[OP_SET], op_count[OP_TEST], op_count[OP_CLEAR],
			op_count[OP_COLLECT]);
		$display("checked %0d results with %0d found indices, %0d mismatches",
			results_checked, indices_found, mismatch_count);
		if (mismatch_count == 0)
			$display("** bitmap_set_bit_enumerator: PASSED **");
		else
			$display("** bitmap_set_bit_enumerator: FAILED **");
		$finish;
	end

endmodule
